/* hw/rtl/mbe_pkg.sv */
`timescale 1ns / 1ps

package mbe_pkg;

  // Fixed-point format of z and c
  localparam int FRAC_BITS = 28;
  localparam int WORD_BITS = 32;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int WIDE_BITS = PROD_BITS + 1;
  localparam int IN_BITS   = 32;

  // Register and result widths
  localparam int ITER_BITS     = 16;
  localparam int LIMIT_BITS    = 4;
  localparam int RESULT_BITS   = 17;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // Width of the |z|^2 compare: holds the full sum and the shifted limit
  localparam int THR_BITS = (2 * FRAC_BITS + LIMIT_BITS > WIDE_BITS) ?
                            (2 * FRAC_BITS + LIMIT_BITS) : WIDE_BITS;

  localparam logic [ITER_BITS-1:0]  MAX_ITER_RST  = ITER_BITS'(1000);
  localparam logic [LIMIT_BITS-1:0] ESC_LIMIT_RST = LIMIT_BITS'(2);

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [WIDE_BITS-1:0] wide_t;

  localparam wide_t WIDE_MAX =
    $signed({{(WIDE_BITS - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}});
  localparam wide_t WIDE_MIN = ~WIDE_MAX;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MAX_ITER  = CFG_IDX_BITS'(0),
    CFG_ESC_LIMIT = CFG_IDX_BITS'(1)
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_RR,
    ST_MUL_II,
    ST_MUL_RI,
    ST_UPDATE,
    ST_MUL_IT,
    ST_RESULT
  } state_e;

  // Operand pairs of the shared multiplier
  typedef enum logic [1:0] {
    OP_RR,
    OP_II,
    OP_RI,
    OP_IT
  } mul_op_e;

  // Sequencer to datapath
  typedef struct packed {
    logic    load;
    logic    mul_en;
    mul_op_e mul_op;
    logic    save_rr;
    logic    save_ii;
    logic    update;
  } dp_ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic escaped;
    logic sq_reaches;
  } dp_stat_t;

  // Clamp a wide signed value to the word range
  function automatic word_t sat_word(wide_t v);
    wide_t r;
    if (v > WIDE_MAX) begin
      r = WIDE_MAX;
    end else if (v < WIDE_MIN) begin
      r = WIDE_MIN;
    end else begin
      r = v;
    end
    return word_t'(r[WORD_BITS-1:0]);
  endfunction

  // Exact product to fixed point: floor shift, then clamp
  function automatic word_t fix_mul(prod_t p);
    wide_t w;
    w = wide_t'(p);
    w = w >>> FRAC_BITS;
    return sat_word(w);
  endfunction

  function automatic word_t sat_add(word_t a, word_t b);
    return sat_word(wide_t'(a) + wide_t'(b));
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    return sat_word(wide_t'(a) - wide_t'(b));
  endfunction

  function automatic word_t load_in(logic signed [IN_BITS-1:0] x);
    return sat_word(wide_t'(x));
  endfunction

endpackage

/* hw/rtl/mbe_mul.sv */
`timescale 1ns / 1ps

// Shared signed multiplier with registered product
module mbe_mul (
  input  logic           clk_i,
  input  logic           en_i,
  input  mbe_pkg::word_t a_i,
  input  mbe_pkg::word_t b_i,
  output mbe_pkg::prod_t p_o
);

  mbe_pkg::prod_t p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

/* hw/rtl/mbe_dp.sv */
`timescale 1ns / 1ps

// z / c registers, operand select, escape test and z update
module mbe_dp (
  input  logic                                clk_i,
  input  mbe_pkg::dp_ctrl_t                   ctrl_i,
  input  logic [mbe_pkg::ITER_BITS-1:0]       iter_i,
  input  logic [mbe_pkg::ITER_BITS-1:0]       max_iter_i,
  input  logic [mbe_pkg::LIMIT_BITS-1:0]      esc_limit_i,
  input  logic signed [mbe_pkg::IN_BITS-1:0]  c_real_i,
  input  logic signed [mbe_pkg::IN_BITS-1:0]  c_imag_i,
  output mbe_pkg::dp_stat_t                   stat_o
);

  mbe_pkg::word_t cr_q, ci_q, zr_q, zi_q;
  mbe_pkg::prod_t rr_q, ii_q;
  mbe_pkg::word_t op_a, op_b;
  mbe_pkg::prod_t prod;
  mbe_pkg::word_t zr_d, zi_d, ri_fix;
  logic [mbe_pkg::THR_BITS-1:0] mag_sq, thr;

  // Operand select for the shared multiplier
  always_comb begin
    case (ctrl_i.mul_op)
      mbe_pkg::OP_RR: begin
        op_a = zr_q;
        op_b = zr_q;
      end
      mbe_pkg::OP_II: begin
        op_a = zi_q;
        op_b = zi_q;
      end
      mbe_pkg::OP_RI: begin
        op_a = zr_q;
        op_b = zi_q;
      end
      default: begin
        op_a = $signed(mbe_pkg::WORD_BITS'(iter_i));
        op_b = $signed(mbe_pkg::WORD_BITS'(iter_i));
      end
    endcase
  end

  mbe_mul u_mul (
    .clk_i (clk_i),
    .en_i  (ctrl_i.mul_en),
    .a_i   (op_a),
    .b_i   (op_b),
    .p_o   (prod)
  );

  // |z|^2 against limit * 2^(2*FRAC); prod holds zi^2 here
  assign mag_sq = mbe_pkg::THR_BITS'($unsigned(rr_q)) + mbe_pkg::THR_BITS'($unsigned(prod));
  assign thr    = mbe_pkg::THR_BITS'(esc_limit_i) << (2 * mbe_pkg::FRAC_BITS);

  assign stat_o.escaped    = mag_sq > thr;
  // prod holds i*i in the result step
  assign stat_o.sq_reaches = $unsigned(prod) >= mbe_pkg::PROD_BITS'(max_iter_i);

  // Next z; prod holds zr*zi here
  assign ri_fix = mbe_pkg::fix_mul(prod);
  assign zr_d   = mbe_pkg::sat_add(
                    mbe_pkg::sat_sub(mbe_pkg::fix_mul(rr_q), mbe_pkg::fix_mul(ii_q)), cr_q);
  assign zi_d   = mbe_pkg::sat_add(mbe_pkg::sat_add(ri_fix, ri_fix), ci_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cr_q <= mbe_pkg::load_in(c_real_i);
      ci_q <= mbe_pkg::load_in(c_imag_i);
      zr_q <= '0;
      zi_q <= '0;
    end else if (ctrl_i.update) begin
      zr_q <= zr_d;
      zi_q <= zi_d;
    end
    if (ctrl_i.save_rr) begin
      rr_q <= prod;
    end
    if (ctrl_i.save_ii) begin
      ii_q <= prod;
    end
  end

endmodule

/* hw/rtl/mbe_seq.sv */
`timescale 1ns / 1ps

// Iteration sequencer: multiplier schedule, counter and result
module mbe_seq (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic [mbe_pkg::ITER_BITS-1:0]           max_iter_i,
  input  mbe_pkg::dp_stat_t                       stat_i,
  output mbe_pkg::dp_ctrl_t                       ctrl_o,
  output logic [mbe_pkg::ITER_BITS-1:0]           iter_o,
  output logic                                    busy_o,
  output logic                                    result_valid_o,
  output logic signed [mbe_pkg::RESULT_BITS-1:0]  escape_value_o
);

  mbe_pkg::state_e state_q, state_d;
  logic [mbe_pkg::ITER_BITS-1:0] iter_q, iter_d;
  logic esc_q, esc_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbe_pkg::ST_IDLE: begin
        if (start_i) state_d = mbe_pkg::ST_MUL_RR;
      end
      mbe_pkg::ST_MUL_RR: state_d = mbe_pkg::ST_MUL_II;
      mbe_pkg::ST_MUL_II: state_d = mbe_pkg::ST_MUL_RI;
      mbe_pkg::ST_MUL_RI: begin
        if (stat_i.escaped) begin
          state_d = mbe_pkg::ST_MUL_IT;
        end else if (iter_q == max_iter_i) begin
          state_d = mbe_pkg::ST_RESULT;
        end else begin
          state_d = mbe_pkg::ST_UPDATE;
        end
      end
      mbe_pkg::ST_UPDATE: state_d = mbe_pkg::ST_MUL_RR;
      mbe_pkg::ST_MUL_IT: state_d = mbe_pkg::ST_RESULT;
      mbe_pkg::ST_RESULT: state_d = mbe_pkg::ST_IDLE;
      default:            state_d = mbe_pkg::ST_IDLE;
    endcase
  end

  // Iteration count and escape flag
  always_comb begin
    iter_d = iter_q;
    esc_d  = esc_q;
    if (state_q == mbe_pkg::ST_IDLE && start_i) begin
      iter_d = '0;
      esc_d  = 1'b0;
    end else if (state_q == mbe_pkg::ST_UPDATE) begin
      iter_d = iter_q + mbe_pkg::ITER_BITS'(1);
    end else if (state_q == mbe_pkg::ST_MUL_RI) begin
      esc_d = stat_i.escaped;
    end
  end

  // Outputs
  always_comb begin
    ctrl_o         = '0;
    ctrl_o.mul_op  = mbe_pkg::OP_RR;
    result_valid_o = 1'b0;
    unique case (state_q)
      mbe_pkg::ST_IDLE: ctrl_o.load = start_i;
      mbe_pkg::ST_MUL_RR: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_op = mbe_pkg::OP_RR;
      end
      mbe_pkg::ST_MUL_II: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_op  = mbe_pkg::OP_II;
        ctrl_o.save_rr = 1'b1;
      end
      mbe_pkg::ST_MUL_RI: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_op  = mbe_pkg::OP_RI;
        ctrl_o.save_ii = 1'b1;
      end
      mbe_pkg::ST_UPDATE: ctrl_o.update = 1'b1;
      mbe_pkg::ST_MUL_IT: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_op = mbe_pkg::OP_IT;
      end
      mbe_pkg::ST_RESULT: result_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign busy_o = state_q != mbe_pkg::ST_IDLE;
  assign iter_o = iter_q;

  // Late escape reports -i, everything else reports zero
  assign escape_value_o = (esc_q && stat_i.sq_reaches) ?
    mbe_pkg::RESULT_BITS'(0) - mbe_pkg::RESULT_BITS'(iter_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbe_pkg::ST_IDLE;
      iter_q  <= '0;
      esc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      esc_q   <= esc_d;
    end
  end

endmodule

/* hw/rtl/mandelbrot_escape_time.sv */
`timescale 1ns / 1ps

// Mandelbrot escape-time unit.
// Input: pulse start with c_real_i / c_imag_i (signed Q3.28) while busy is low;
// the item is taken at that edge and busy rises on the next cycle.
// Output: result_valid_o is high for exactly one cycle with escape_value_o,
// which is -i when the point escaped at iteration i with i*i >= the iteration
// limit, and 0 otherwise. The receiver cannot stall; the result must be taken then.
// Config: cfg_valid_i / cfg_ready_o write cfg_data_i into register cfg_index_i
// (0: iteration limit, 1: escape limit, others ignored). cfg_ready_o is always
// high; write only while busy is low.
// Schedule: one multiplier is shared by zr*zr, zi*zi and zr*zi, and by i*i
// once the point escapes; each iteration steps through zr*zr, zi*zi, zr*zi and
// then the z update. Busy stays high through the result step, the strobe in its
// last busy cycle; a new item can be taken on the cycle after. One item at a time.
// Reset: asynchronous, active low; the sequencer returns to idle,
// the iteration limit to 1000 and the escape limit to 2.
module mandelbrot_escape_time (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [mbe_pkg::IN_BITS-1:0]       c_real_i,
  input  logic signed [mbe_pkg::IN_BITS-1:0]       c_imag_i,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [mbe_pkg::CFG_IDX_BITS-1:0]         cfg_index_i,
  input  logic [mbe_pkg::CFG_DATA_BITS-1:0]        cfg_data_i,
  output logic                                     result_valid_o,
  output logic signed [mbe_pkg::RESULT_BITS-1:0]   escape_value_o
);

  logic [mbe_pkg::ITER_BITS-1:0]  max_iter_q;
  logic [mbe_pkg::LIMIT_BITS-1:0] esc_limit_q;
  logic [mbe_pkg::ITER_BITS-1:0]  iter;
  mbe_pkg::dp_ctrl_t              ctrl;
  mbe_pkg::dp_stat_t              stat;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q  <= mbe_pkg::MAX_ITER_RST;
      esc_limit_q <= mbe_pkg::ESC_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        mbe_pkg::CFG_MAX_ITER:  max_iter_q  <= cfg_data_i[mbe_pkg::ITER_BITS-1:0];
        mbe_pkg::CFG_ESC_LIMIT: esc_limit_q <= cfg_data_i[mbe_pkg::LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  mbe_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .max_iter_i     (max_iter_q),
    .stat_i         (stat),
    .ctrl_o         (ctrl),
    .iter_o         (iter),
    .busy_o         (busy),
    .result_valid_o (result_valid_o),
    .escape_value_o (escape_value_o)
  );

  mbe_dp u_dp (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .iter_i      (iter),
    .max_iter_i  (max_iter_q),
    .esc_limit_i (esc_limit_q),
    .c_real_i    (c_real_i),
    .c_imag_i    (c_imag_i),
    .stat_o      (stat)
  );

`ifndef SYNTHESIS
  // One strobe per item
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // Results only come while an item is in flight
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe while idle");

  // Accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !result_valid_o))
    else $error("accepted item did not start iterating");

  // Result is never positive
  a_result_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (escape_value_o[mbe_pkg::RESULT_BITS-1] || escape_value_o == '0))
    else $error("positive escape value");
`endif

endmodule
